// ----- hw/rtl/ptz_pkg.sv -----
// ----------------------------------------------------------------------------
// ptz_pkg
// Types and constants for the POSIX TZ fixed-offset parser.
// ----------------------------------------------------------------------------
package ptz_pkg;

    typedef enum logic [3:0] {
        PH_LETTERS = 4'd0,
        PH_NAME    = 4'd1,
        PH_SIGN    = 4'd2,
        PH_HFIRST  = 4'd3,
        PH_HRUN    = 4'd4,
        PH_MFIRST  = 4'd5,
        PH_MRUN    = 4'd6,
        PH_SFIRST  = 4'd7,
        PH_SRUN    = 4'd8,
        PH_DONE    = 4'd9,
        PH_FAIL    = 4'd10
    } phase_t;

    localparam int unsigned NUM_W  = 31;        // largest run value 2147483639
    localparam int unsigned PH_W   = 43;        // hours * 3600
    localparam int unsigned PM_W   = 37;        // minutes * 60
    localparam int unsigned TOT_W  = 44;
    localparam int unsigned QX_W   = 16;        // |offset| + 450 before saturation
    localparam int unsigned PROD_W = 33;

    localparam logic [NUM_W-1:0] DIGIT_LIMIT  = 31'd214748363;
    localparam logic [11:0]      SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]       SEC_PER_MIN  = 6'd60;
    localparam logic [QX_W-1:0]  HALF_QUARTER = 16'd450;
    // |offset| at or above this rounds to 57 or more quarters: clamps anyway
    localparam logic [TOT_W-1:0] SAT_LIMIT    = 44'd50850;
    // floor(x / 900) == (x * RECIP_900) >> RECIP_SHIFT for x < 125203
    localparam logic [16:0]      RECIP_900    = 17'd74566;
    localparam int unsigned      RECIP_SHIFT  = 26;
    localparam logic [6:0]       Q_POS_MAX    = 7'd56;
    localparam logic [6:0]       Q_NEG_MAX    = 7'd48;
    localparam logic [6:0]       Q_SAT        = 7'd63;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

endpackage

// ----- hw/rtl/posix_tz_offset_parser.sv -----
// ----------------------------------------------------------------------------
// posix_tz_offset_parser
// Parses the fixed UTC offset of a POSIX TZ string, one character per word.
// ----------------------------------------------------------------------------
// Input channel (char_valid / char_stall / char_in): one byte of the TZ
// string per word, a NUL byte ends the string. Non-NUL bytes only step the
// parser and produce nothing. Each NUL produces exactly one result word on
// the output channel (result_valid / result_stall / parse_ok,
// local_offset_sec, quarter_hours) and returns the parser to its start.
// Throughput: one character per cycle, back to back, while char_stall is low;
// a NUL is accepted like any other byte.
// The offset math runs in a five-stage pipeline behind the parser: capture,
// the hours/minutes products, the sum, range check, and the quarter-hour
// division by reciprocal multiply, then the output register.
// Stall: a stalled result holds; each pipeline stage keeps moving while the
// stage after it has room, so the input (any byte) is stalled only when
// every stage holds a result and the output is stalled.
// Reset: the parser returns to the skip-letters phase and the pipeline
// empties; result_valid is low.
// ----------------------------------------------------------------------------
module posix_tz_offset_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  logic [7:0]        char_in,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              parse_ok,
    output logic signed [31:0] local_offset_sec,
    output logic signed [6:0] quarter_hours
);
    import ptz_pkg::*;

    // parser state
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [NUM_W-1:0] hours_reg, hours_next;
    logic [NUM_W-1:0] minutes_reg, minutes_next;
    logic [NUM_W-1:0] seconds_reg, seconds_next;

    // stage 1: snapshot at NUL
    logic             v1_reg, ok1_reg, neg1_reg;
    logic [NUM_W-1:0] h1_reg, m1_reg, s1_reg;
    // stage 2: products
    logic             v2_reg, ok2_reg, neg2_reg;
    logic [PH_W-1:0]  ph2_reg;
    logic [PM_W-1:0]  pm2_reg;
    logic [NUM_W-1:0] s2_reg;
    // stage 3: total seconds
    logic             v3_reg, ok3_reg, neg3_reg;
    logic [TOT_W-1:0] tot3_reg;
    // stage 4: signed offset, range check, rounding input
    logic             v4_reg, ok4_reg, lneg4_reg, sat4_reg;
    logic [31:0]      local4_reg;
    logic [QX_W-1:0]  x4_reg;
    // stage 5: reciprocal product
    logic             v5_reg, ok5_reg, lneg5_reg, sat5_reg;
    logic [31:0]      local5_reg;
    logic [PROD_W-1:0] prod5_reg;
    // output register
    logic             vo_reg, ok_o_reg;
    logic [31:0]      local_o_reg;
    logic [6:0]       q_o_reg;

    logic adv1, adv2, adv3, adv4, adv5, adv_o;
    logic char_acc, is_nul;

    // ---------------- handshake / pipeline advance ----------------
    assign adv_o = !vo_reg || !result_stall;
    assign adv5  = !v5_reg || adv_o;
    assign adv4  = !v4_reg || adv5;
    assign adv3  = !v3_reg || adv4;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;

    assign is_nul     = (char_in == CH_NUL);
    assign char_stall = !adv1;
    assign char_acc   = char_valid && !char_stall;

    // ---------------- parser step ----------------
    always_comb
    begin
        phase_t           cur;
        logic             used;
        logic             is_dig, is_let;
        logic [NUM_W-1:0] sel;
        logic [NUM_W-1:0] acc;
        logic             ovf;
        logic [3:0]       dval;

        phase_next   = phase_reg;
        neg_next     = neg_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;

        cur    = phase_reg;
        used   = 1'b0;
        is_dig = (char_in inside {[8'h30:8'h39]});
        is_let = (char_in inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        dval   = 4'(char_in - CH_ZERO);

        case (phase_reg)
            PH_MFIRST, PH_MRUN: sel = minutes_reg;
            PH_SFIRST, PH_SRUN: sel = seconds_reg;
            default:            sel = hours_reg;
        endcase
        ovf = (sel > DIGIT_LIMIT);
        acc = NUM_W'({sel, 3'b000} + {2'b00, sel, 1'b0} + {{(NUM_W-1){1'b0}}, dval});

        if (cur == PH_LETTERS)
        begin
            if (is_let)
                used = 1'b1;
            else if (char_in == CH_LT)
            begin
                phase_next = PH_NAME;
                used       = 1'b1;
            end
            else
                cur = PH_SIGN;
        end
        else if (cur == PH_NAME)
        begin
            if (char_in == CH_GT)
                phase_next = PH_SIGN;
            used = 1'b1;
        end

        if (!used && cur == PH_SIGN)
        begin
            if (char_in == CH_PLUS)
            begin
                phase_next = PH_HFIRST;
                used       = 1'b1;
            end
            else if (char_in == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_HFIRST;
                used       = 1'b1;
            end
            else
                cur = PH_HFIRST;
        end

        if (!used)
        begin
            case (cur)
                PH_HFIRST, PH_HRUN:
                begin
                    if (is_dig)
                    begin
                        phase_next = ovf ? PH_FAIL : PH_HRUN;
                        if (!ovf)
                            hours_next = acc;
                    end
                    else if (cur == PH_HFIRST)
                        phase_next = PH_FAIL;
                    else
                        phase_next = (char_in == CH_COLON) ? PH_MFIRST : PH_DONE;
                end
                PH_MFIRST, PH_MRUN:
                begin
                    if (is_dig)
                    begin
                        phase_next = ovf ? PH_FAIL : PH_MRUN;
                        if (!ovf)
                            minutes_next = acc;
                    end
                    else if (cur == PH_MFIRST)
                        phase_next = PH_FAIL;
                    else
                        phase_next = (char_in == CH_COLON) ? PH_SFIRST : PH_DONE;
                end
                PH_SFIRST, PH_SRUN:
                begin
                    if (is_dig)
                    begin
                        phase_next = ovf ? PH_FAIL : PH_SRUN;
                        if (!ovf)
                            seconds_next = acc;
                    end
                    else
                        phase_next = (cur == PH_SFIRST) ? PH_FAIL : PH_DONE;
                end
                default:
                    phase_next = cur;   // done, failed and unused codes hold
            endcase
        end

        if (is_nul)
        begin
            phase_next   = PH_LETTERS;
            neg_next     = 1'b0;
            hours_next   = '0;
            minutes_next = '0;
            seconds_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LETTERS;
            neg_reg     <= 1'b0;
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
        end
        else if (char_acc)
        begin
            phase_reg   <= phase_next;
            neg_reg     <= neg_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
        end
    end

    // ---------------- offset pipeline: valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= char_acc && is_nul;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv5)
                v5_reg <= v4_reg;
            if (adv_o)
                vo_reg <= v5_reg;
        end
    end

    // ---------------- offset pipeline: payload ----------------
    logic             fits4_next;
    logic [31:0]      local4_next;
    logic             sat4_next;
    logic [QX_W-1:0]  x4_next;
    logic [6:0]       qmag_o, qlim_o, q_o_next;

    always_comb
    begin
        // total <= 2^31-1 when local is positive, total <= 2^31 when negative
        fits4_next = (tot3_reg[TOT_W-1:31] == '0) ||
                     (!neg3_reg && tot3_reg == (TOT_W'(1) << 31));
        local4_next = neg3_reg ? tot3_reg[31:0] : 32'(-tot3_reg[31:0]);
        sat4_next   = (tot3_reg >= SAT_LIMIT);
        x4_next     = tot3_reg[QX_W-1:0] + HALF_QUARTER;

        qmag_o   = sat5_reg ? Q_SAT : prod5_reg[PROD_W-1:RECIP_SHIFT];
        if (lneg5_reg)
        begin
            qlim_o   = (qmag_o > Q_NEG_MAX) ? Q_NEG_MAX : qmag_o;
            q_o_next = 7'(-qlim_o);
        end
        else
        begin
            qlim_o   = (qmag_o > Q_POS_MAX) ? Q_POS_MAX : qmag_o;
            q_o_next = qlim_o;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && char_acc && is_nul)
        begin
            ok1_reg  <= (phase_reg inside {PH_HRUN, PH_MRUN, PH_SRUN, PH_DONE});
            neg1_reg <= neg_reg;
            h1_reg   <= hours_reg;
            m1_reg   <= minutes_reg;
            s1_reg   <= seconds_reg;
        end
        if (adv2)
        begin
            ok2_reg  <= ok1_reg;
            neg2_reg <= neg1_reg;
            ph2_reg  <= {{(PH_W-NUM_W){1'b0}}, h1_reg} * {{(PH_W-12){1'b0}}, SEC_PER_HOUR};
            pm2_reg  <= {{(PM_W-NUM_W){1'b0}}, m1_reg} * {{(PM_W-6){1'b0}}, SEC_PER_MIN};
            s2_reg   <= s1_reg;
        end
        if (adv3)
        begin
            ok3_reg  <= ok2_reg;
            neg3_reg <= neg2_reg;
            tot3_reg <= {{(TOT_W-PH_W){1'b0}}, ph2_reg} +
                        {{(TOT_W-PM_W){1'b0}}, pm2_reg} +
                        {{(TOT_W-NUM_W){1'b0}}, s2_reg};
        end
        if (adv4)
        begin
            // invalid strings carry zeros to the output
            ok4_reg    <= ok3_reg && fits4_next;
            local4_reg <= (ok3_reg && fits4_next) ? local4_next : 32'd0;
            lneg4_reg  <= ok3_reg && fits4_next && !neg3_reg && (tot3_reg != '0);
            sat4_reg   <= ok3_reg && fits4_next && sat4_next;
            x4_reg     <= (ok3_reg && fits4_next && !sat4_next) ? x4_next : '0;
        end
        if (adv5)
        begin
            ok5_reg    <= ok4_reg;
            lneg5_reg  <= lneg4_reg;
            sat5_reg   <= sat4_reg;
            local5_reg <= local4_reg;
            prod5_reg  <= {{(PROD_W-QX_W){1'b0}}, x4_reg} *
                          {{(PROD_W-17){1'b0}}, RECIP_900};
        end
        if (adv_o)
        begin
            ok_o_reg    <= ok5_reg;
            local_o_reg <= local5_reg;
            q_o_reg     <= q_o_next;
        end
    end

    assign result_valid     = vo_reg;
    assign parse_ok         = ok_o_reg;
    assign local_offset_sec = signed'(local_o_reg);
    assign quarter_hours    = signed'(q_o_reg);

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !parse_ok) |-> (local_offset_sec == 0 && quarter_hours == 0))
        else $error("invalid result carries a nonzero offset");

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (quarter_hours >= -7'sd48 && quarter_hours <= 7'sd56))
        else $error("quarter_hours outside clamp range");

    a_q_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && local_offset_sec >= 0) |-> (quarter_hours >= 0))
        else $error("quarter_hours sign disagrees with offset");

    a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && char_in == CH_NUL) |=> (phase_reg == PH_LETTERS))
        else $error("parser not back at start after NUL");

endmodule
